// File: sv/slx_pkg.sv
// Package for the source lexer: token tags, lexer modes, token record type
// and the character class and keyword lookup functions. No dependencies.
package slx_pkg;

	localparam int POSITION_BITS = 16;
	localparam int TAG_BITS      = 5;
	localparam int LEN_BITS      = 16;
	localparam int MODE_BITS     = 3;
	localparam int PREFIX_LEN    = 6;
	localparam int KW_COUNT      = 6;

	localparam logic [TAG_BITS-1:0] T_END     = 5'd0;
	localparam logic [TAG_BITS-1:0] T_ASSIGN  = 5'd1;
	localparam logic [TAG_BITS-1:0] T_BANG    = 5'd2;
	localparam logic [TAG_BITS-1:0] T_LT      = 5'd3;
	localparam logic [TAG_BITS-1:0] T_GT      = 5'd4;
	localparam logic [TAG_BITS-1:0] T_PAIR_OFS = 5'd4;
	localparam logic [TAG_BITS-1:0] T_SEMI    = 5'd9;
	localparam logic [TAG_BITS-1:0] T_PLUS    = 5'd10;
	localparam logic [TAG_BITS-1:0] T_MINUS   = 5'd11;
	localparam logic [TAG_BITS-1:0] T_STAR    = 5'd12;
	localparam logic [TAG_BITS-1:0] T_SLASH   = 5'd13;
	localparam logic [TAG_BITS-1:0] T_LBRACE  = 5'd14;
	localparam logic [TAG_BITS-1:0] T_RBRACE  = 5'd15;
	localparam logic [TAG_BITS-1:0] T_LPAREN  = 5'd16;
	localparam logic [TAG_BITS-1:0] T_RPAREN  = 5'd17;
	localparam logic [TAG_BITS-1:0] T_DECIMAL = 5'd18;
	localparam logic [TAG_BITS-1:0] T_IDENT   = 5'd19;
	localparam logic [TAG_BITS-1:0] T_KW_FIRST = 5'd20;
	localparam logic [TAG_BITS-1:0] T_ERROR   = 5'd26;

	localparam logic [MODE_BITS-1:0] M_IDLE    = 3'd0;
	localparam logic [MODE_BITS-1:0] M_OP      = 3'd1;
	localparam logic [MODE_BITS-1:0] M_NUM     = 3'd2;
	localparam logic [MODE_BITS-1:0] M_IDENT   = 3'd3;
	localparam logic [MODE_BITS-1:0] M_COMMENT = 3'd4;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	typedef logic [PREFIX_LEN-1:0][7:0] word_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [LEN_BITS-1:0] length;
		logic [LEN_BITS-1:0] start;
		logic                last;
	} tok_t;

	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} res_pair_t;

	localparam word_t KW_CHR [KW_COUNT] = '{
		{"n", "r", "u", "t", "e", "r"},
		{8'h00, 8'h00, 8'h00, "t", "n", "i"},
		{8'h00, 8'h00, "e", "u", "r", "t"},
		{8'h00, "e", "s", "l", "a", "f"},
		{8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
		{8'h00, 8'h00, "e", "s", "l", "e"}
	};
	localparam logic [LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
		16'd6, 16'd3, 16'd4, 16'd5, 16'd2, 16'd4
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c == "\t") || (c == "\n");
	endfunction

	function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
		return (v != LEN_MAX) ? v + 1'b1 : v;
	endfunction

	function automatic logic [TAG_BITS-1:0] lead_tag(input logic [7:0] c);
		logic [TAG_BITS-1:0] t;
		unique case (c)
			"=":     t = T_ASSIGN;
			"!":     t = T_BANG;
			"<":     t = T_LT;
			">":     t = T_GT;
			"/":     t = T_SLASH;
			default: t = T_END;
		endcase
		return t;
	endfunction

	function automatic logic [TAG_BITS-1:0] single_tag(input logic [7:0] c);
		logic [TAG_BITS-1:0] t;
		unique case (c)
			";":     t = T_SEMI;
			"+":     t = T_PLUS;
			"-":     t = T_MINUS;
			"*":     t = T_STAR;
			"{":     t = T_LBRACE;
			"}":     t = T_RBRACE;
			"(":     t = T_LPAREN;
			")":     t = T_RPAREN;
			default: t = T_END;
		endcase
		return t;
	endfunction

	// Bytes past the word length are zero, so a full prefix compare suffices.
	function automatic logic [TAG_BITS-1:0] word_tag(input word_t pfx,
			input logic [LEN_BITS-1:0] len);
		logic [TAG_BITS-1:0] t;
		t = T_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if ((len == KW_LEN[k]) && (pfx == KW_CHR[k])) begin
				t = T_KW_FIRST + TAG_BITS'(k);
			end
		end
		return t;
	endfunction

endpackage

// File: sv/slx_byte_if.sv
// Input channel of the source lexer: one source byte or end-of-source marker.
// Depends on nothing.
interface slx_byte_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_byte;

	modport source (output valid, output opcode, output char_byte, input ready);
	modport sink (input valid, input opcode, input char_byte, output ready);
endinterface

// File: sv/slx_token_if.sv
// Output channel of the source lexer: one token per transaction.
// Depends on slx_pkg for field widths.
interface slx_token_if;
	logic                          valid;
	logic                          ready;
	logic [slx_pkg::TAG_BITS-1:0]  token_tag;
	logic [slx_pkg::LEN_BITS-1:0]  token_length;
	logic [slx_pkg::LEN_BITS-1:0]  token_start;
	logic                          last_of_run;

	modport source (output valid, output token_tag, output token_length,
		output token_start, output last_of_run, input ready);
	modport sink (input valid, input token_tag, input token_length,
		input token_start, input last_of_run, output ready);
endinterface

// File: sv/slx_core.sv
// Lexer core: input register, lexer state and the per-byte token decision.
// Produces up to two tokens per input transaction. Depends on slx_pkg, slx_byte_if.
module slx_core (
	input  logic               clk,
	input  logic               arst_n,
	slx_byte_if.sink           source,
	input  logic               room,
	output slx_pkg::res_pair_t res
);
	import slx_pkg::*;

	logic                     valid_s1;
	logic                     opcode_s1;
	logic [7:0]               char_s1;
	logic                     proc;

	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [MODE_BITS-1:0]     mode_q, mode_d;
	logic [LEN_BITS-1:0]      pstart_q, pstart_d;
	logic [LEN_BITS-1:0]      plen_q, plen_d;
	logic [TAG_BITS-1:0]      pop_q, pop_d;
	word_t                    pfx_q, pfx_d;

	logic                     fl_v;
	tok_t                     fl_tok;
	logic                     f_v, e_v, fresh;
	tok_t                     e_tok;
	logic [LEN_BITS-1:0]      cur_start;
	logic [TAG_BITS-1:0]      lt, st;

	assign proc = valid_s1 && room;
	assign source.ready = !valid_s1 || room;
	assign cur_start = LEN_BITS'(pos_q);
	assign lt = lead_tag(char_s1);
	assign st = single_tag(char_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (source.ready) begin
			valid_s1 <= source.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (source.ready && source.valid) begin
			opcode_s1 <= source.opcode;
			char_s1   <= source.char_byte;
		end
	end

	always_comb begin
		fl_v   = 1'b0;
		fl_tok = '0;
		unique case (mode_q)
			M_OP: begin
				fl_v          = 1'b1;
				fl_tok.tag    = pop_q;
				fl_tok.length = LEN_BITS'(1);
				fl_tok.start  = pstart_q;
			end
			M_NUM: begin
				fl_v          = 1'b1;
				fl_tok.tag    = T_DECIMAL;
				fl_tok.length = plen_q;
				fl_tok.start  = pstart_q;
			end
			M_IDENT: begin
				fl_v          = 1'b1;
				fl_tok.tag    = word_tag(pfx_q, plen_q);
				fl_tok.length = plen_q;
				fl_tok.start  = pstart_q;
			end
			default: begin
				fl_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		pos_d    = pos_q;
		mode_d   = mode_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		pop_d    = pop_q;
		pfx_d    = pfx_q;
		f_v      = 1'b0;
		e_v      = 1'b0;
		e_tok    = '0;
		fresh    = 1'b0;
		if (opcode_s1) begin
			f_v      = fl_v;
			e_v      = 1'b1;
			pos_d    = '0;
			mode_d   = M_IDLE;
			pstart_d = '0;
			plen_d   = '0;
			pop_d    = '0;
			pfx_d    = '0;
		end else begin
			pos_d = pos_q + 1'b1;
			unique case (mode_q)
				M_OP: begin
					if (pop_q == T_SLASH) begin
						if (char_s1 == "/") begin
							mode_d = M_COMMENT;
						end else begin
							f_v    = 1'b1;
							mode_d = M_IDLE;
							fresh  = 1'b1;
						end
					end else if ((char_s1 == "=") && (pop_q >= T_ASSIGN) && (pop_q <= T_GT)) begin
						e_v          = 1'b1;
						e_tok.tag    = pop_q + T_PAIR_OFS;
						e_tok.length = LEN_BITS'(2);
						e_tok.start  = pstart_q;
						mode_d       = M_IDLE;
					end else begin
						f_v    = 1'b1;
						mode_d = M_IDLE;
						fresh  = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit(char_s1)) begin
						plen_d = sat_inc(plen_q);
					end else begin
						f_v    = 1'b1;
						mode_d = M_IDLE;
						fresh  = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_ident_start(char_s1) || is_digit(char_s1)) begin
						if (plen_q < LEN_BITS'(PREFIX_LEN)) begin
							pfx_d[plen_q[2:0]] = char_s1;
						end
						plen_d = sat_inc(plen_q);
					end else begin
						f_v    = 1'b1;
						mode_d = M_IDLE;
						fresh  = 1'b1;
					end
				end
				M_COMMENT: begin
					if (char_s1 == "\n") begin
						mode_d = M_IDLE;
					end
				end
				default: begin
					mode_d = M_IDLE;
					fresh  = 1'b1;
				end
			endcase
			if (fresh) begin
				priority if (is_space(char_s1)) begin
					mode_d = M_IDLE;
				end else if (lt != T_END) begin
					mode_d   = M_OP;
					pop_d    = lt;
					pstart_d = cur_start;
				end else if (st != T_END) begin
					e_v          = 1'b1;
					e_tok.tag    = st;
					e_tok.length = LEN_BITS'(1);
					e_tok.start  = cur_start;
				end else if (is_digit(char_s1)) begin
					mode_d   = M_NUM;
					pstart_d = cur_start;
					plen_d   = LEN_BITS'(1);
				end else if (is_ident_start(char_s1)) begin
					mode_d   = M_IDENT;
					pstart_d = cur_start;
					plen_d   = LEN_BITS'(1);
					pfx_d    = '0;
					pfx_d[0] = char_s1;
				end else begin
					e_v          = 1'b1;
					e_tok.tag    = T_ERROR;
					e_tok.length = LEN_BITS'(1);
					e_tok.start  = cur_start;
				end
			end
		end
	end

	always_comb begin
		res.v0        = proc && (f_v || e_v);
		res.v1        = proc && f_v && e_v;
		res.t0        = f_v ? fl_tok : e_tok;
		res.t0.last   = !(f_v && e_v);
		res.t1        = e_tok;
		res.t1.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			mode_q   <= M_IDLE;
			pstart_q <= '0;
			plen_q   <= '0;
			pop_q    <= '0;
			pfx_q    <= '0;
		end else if (proc) begin
			pos_q    <= pos_d;
			mode_q   <= mode_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			pop_q    <= pop_d;
			pfx_q    <= pfx_d;
		end
	end

endmodule

// File: sv/slx_fifo.sv
// Token result buffer: four entries, takes up to two tokens per cycle,
// hands out one per transaction. Depends on slx_pkg, slx_token_if.
module slx_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  slx_pkg::res_pair_t res,
	output logic               room,
	slx_token_if.source        tokens
);
	import slx_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	tok_t                mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [PTR_BITS:0]   cnt_q;
	logic                pop;
	tok_t                head;

	assign room = cnt_q <= (PTR_BITS+1)'(DEPTH - 2);
	assign pop  = tokens.valid && tokens.ready;
	assign head = mem_q[rd_q];

	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_tag    = head.tag;
	assign tokens.token_length = head.length;
	assign tokens.token_start  = head.start;
	assign tokens.last_of_run  = head.last;

	always_ff @(posedge clk) begin
		if (res.v0) begin
			mem_q[wr_q] <= res.t0;
		end
		if (res.v1) begin
			mem_q[wr_q + 1'b1] <= res.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_BITS'(res.v0) + PTR_BITS'(res.v1);
			rd_q  <= rd_q + PTR_BITS'(pop);
			cnt_q <= cnt_q + (PTR_BITS+1)'(res.v0) + (PTR_BITS+1)'(res.v1)
				- (PTR_BITS+1)'(pop);
		end
	end

endmodule

// File: sv/source_lexer_top.sv
// Source lexer top level: byte input channel in, token channel out.
// Depends on slx_pkg, slx_byte_if, slx_token_if, slx_core, slx_fifo.
//
// Usage:
//   source : one transaction per source byte (opcode 0) or end of source
//            (opcode 1). Bytes are numbered from 0 after reset or after an
//            end-of-source transaction.
//   tokens : one transaction per token; last_of_run marks the final token
//            caused by one input transaction. An input transaction gives
//            zero, one or two tokens.
//   Path:    a token passes the input register, then the result buffer,
//            before it is offered at the token port.
//   Throughput: one input transaction per cycle while each gives at most
//            one token and the result buffer has room; a transaction with
//            two tokens takes two transactions at the single token read port.
//   Stall: the four-entry result buffer absorbs output back-pressure;
//            source.ready drops with a byte held and under two entries free.
//   Reset: arst_n clears the lexer to idle at byte offset 0 and empties
//            the buffer; no tokens are pending.
module source_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	slx_byte_if.sink    source,
	slx_token_if.source tokens
);
	import slx_pkg::*;

	res_pair_t res;
	logic      room;

	slx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.source (source),
		.room   (room),
		.res    (res)
	);

	slx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.room   (room),
		.tokens (tokens)
	);

endmodule
